// ----- hw/rtl/msr_pkg.sv -----
package msr_pkg;

	localparam int DUTY_W   = 27;
	localparam int RATE_W   = 34;
	localparam int ELAP_W   = 16;
	localparam int QUOT_W   = 27;
	localparam int DVD_W    = 37;
	localparam int PROD_W   = RATE_W + ELAP_W;
	localparam int DIVISOR  = 1000;
	localparam int EST_LSB  = 5;
	localparam int RECIP_SH = 36;

	// floor(2^36 / 31.25): ((x >> 5) * RECIP_1000) >> 36 is x / 1000 or one short
	localparam logic [31:0] RECIP_1000 = 32'd2199023255;

	localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

	localparam logic CFG_MIN_DUTY   = 1'b0;
	localparam logic CFG_ACCEL_DIST = 1'b1;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_ACCEL = 3'd1,
		PH_WORK  = 3'd2,
		PH_DECEL = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	typedef struct packed {
		logic load;
		logic rate;
		logic mul;
		logic div;
		logic fix;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

// ----- hw/rtl/msr_ctrl.sv -----
module msr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  msr_pkg::dp_sts_t    sts,
	output msr_pkg::ctrl_cmd_t  cmd
);
	import msr_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_RATE   = 6'b000010,
		S_MUL    = 6'b000100,
		S_DIV    = 6'b001000,
		S_FIX    = 6'b010000,
		S_COMMIT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RATE;
				end
			end
			S_RATE: begin
				cmd.rate = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_d = S_FIX;
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/msr_datapath.sv -----
module msr_datapath #(
	parameter int PERIOD = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  msr_pkg::ctrl_cmd_t  cmd,
	output msr_pkg::dp_sts_t    sts,
	input  logic [10:0]         min_start_duty,
	input  logic [15:0]         accel_distance,
	input  logic                start_req,
	input  logic                stop_req,
	input  logic                min_temp_ok,
	input  logic [10:0]         target_duty,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [10:0]         motor_compare,
	output logic                motor_on,
	output logic [2:0]          phase,
	output logic                save_request,
	output logic                blower_off
);
	import msr_pkg::*;

	localparam logic [15:0]       PERIOD_W = 16'(PERIOD);
	localparam logic [PROD_W-1:0] SAT_LIM  = PROD_W'(DIVISOR) << QUOT_W;
	localparam logic [DVD_W-1:0]  DVS      = DVD_W'(DIVISOR);

	function automatic logic [15:0] clamp_cmp(input logic [DUTY_W-1:0] d);
		logic [DUTY_W:0] r;
		logic [15:0]     c;
		r = {1'b0, d} + (DUTY_W+1)'(32'h8000);
		c = 16'(r[DUTY_W:16]);
		if (c > PERIOD_W) begin
			c = PERIOD_W;
		end
		return c;
	endfunction

	logic              req_start_q, req_stop_q, req_temp_q;
	logic [10:0]       req_target_q;

	logic [DUTY_W-1:0] duty_q;
	logic              rate_neg_q;
	logic [RATE_W-1:0] rate_mag_q;
	logic [ELAP_W-1:0] elapsed_q;
	phase_t            phase_q;
	logic              en_q;

	logic              sat_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [QUOT_W-1:0] qest_q;
	logic [QUOT_W-1:0] quot_q;

	logic              out_valid_q;
	logic [10:0]       out_cmp_q;
	logic              out_on_q;
	phase_t            out_phase_q;
	logic              out_save_q;

	logic [DUTY_W-1:0] min_q16, target_q16, end_q16, diff_mag;
	logic              diff_neg;
	logic [42:0]       rate_prod;
	logic [ELAP_W-1:0] elap_inc;
	logic [PROD_W-1:0] step_prod;
	logic [63:0]       recip_prod;
	logic [DVD_W-1:0]  qest_x1000;
	logic [DVD_W-1:0]  qest_rem;

	logic [DUTY_W:0]   inc_mag;
	logic [DUTY_W+1:0] moved_sum;
	logic [DUTY_W-1:0] moved;
	logic              dir_add;
	phase_t            eph, nph;
	logic [DUTY_W-1:0] nduty;
	logic              drive, en_next, save_next, clr_elapsed;
	logic [15:0]       ncmp;

	assign min_q16    = {min_start_duty, 16'b0};
	assign target_q16 = {req_target_q, 16'b0};

	always_comb begin
		end_q16    = req_stop_q ? duty_q : target_q16;
		diff_neg   = end_q16 < min_q16;
		diff_mag   = diff_neg ? (min_q16 - end_q16) : (end_q16 - min_q16);
		rate_prod  = 43'(diff_mag) * 43'(accel_distance);
		elap_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		step_prod  = PROD_W'(rate_mag_q) * PROD_W'(elapsed_q);
		recip_prod = 64'(dvd_q[DVD_W-1:EST_LSB]) * 64'(RECIP_1000);
		// times 1000 as 1024 - 16 - 8
		qest_x1000 = (DVD_W'(qest_q) << 10) - (DVD_W'(qest_q) << 4) - (DVD_W'(qest_q) << 3);
		qest_rem   = dvd_q - qest_x1000;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_start_q  <= start_req;
			req_stop_q   <= stop_req;
			req_temp_q   <= min_temp_ok;
			req_target_q <= target_duty;
		end
		if (cmd.mul) begin
			sat_q <= step_prod >= SAT_LIM;
			dvd_q <= (step_prod >= SAT_LIM) ? '0 : step_prod[DVD_W-1:0];
		end
		if (cmd.div) begin
			qest_q <= recip_prod[RECIP_SH+QUOT_W-1:RECIP_SH];
		end
		if (cmd.fix) begin
			quot_q <= qest_q + QUOT_W'(qest_rem >= DVS);
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		inc_mag = sat_q ? (DUTY_W+1)'(1) << DUTY_W : {1'b0, quot_q};
		if (req_stop_q) begin
			eph = PH_DECEL;
		end else if (req_start_q) begin
			eph = PH_WAIT;
		end else begin
			eph = phase_q;
		end
		dir_add   = (eph == PH_ACCEL) ? !rate_neg_q : rate_neg_q;
		moved_sum = dir_add ? ({2'b0, duty_q} + {1'b0, inc_mag})
		                    : ({2'b0, duty_q} - {1'b0, inc_mag});
		if (moved_sum[DUTY_W+1]) begin
			moved = '0;
		end else if (moved_sum[DUTY_W]) begin
			moved = DUTY_MAX;
		end else begin
			moved = moved_sum[DUTY_W-1:0];
		end

		nph         = eph;
		nduty       = duty_q;
		drive       = 1'b0;
		save_next   = 1'b0;
		clr_elapsed = 1'b0;
		case (eph)
			PH_WAIT: begin
				if (req_temp_q) begin
					nph         = PH_ACCEL;
					nduty       = min_q16;
					drive       = 1'b1;
					clr_elapsed = 1'b1;
				end
			end
			PH_ACCEL: begin
				drive = 1'b1;
				if (duty_q < target_q16) begin
					nduty = moved;
				end else begin
					nduty = target_q16;
					nph   = PH_WORK;
				end
			end
			PH_WORK: begin
				nduty = target_q16;
				drive = 1'b1;
			end
			PH_DECEL: begin
				if (duty_q > min_q16) begin
					nduty = moved;
					drive = 1'b1;
				end else begin
					nph       = PH_STOP;
					nduty     = '0;
					save_next = 1'b1;
				end
			end
			default: begin
				nph = PH_STOP;
			end
		endcase

		ncmp    = clamp_cmp(nduty);
		en_next = en_q;
		if (drive && ncmp > 16'd1) begin
			en_next = 1'b1;
		end
		if (save_next) begin
			en_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			rate_neg_q  <= 1'b0;
			rate_mag_q  <= '0;
			elapsed_q   <= '0;
			phase_q     <= PH_STOP;
			en_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rate) begin
				elapsed_q <= req_stop_q ? '0 : elap_inc;
				if (req_start_q || req_stop_q) begin
					rate_neg_q <= diff_neg;
					rate_mag_q <= rate_prod[42:9];
				end
			end
			if (cmd.commit) begin
				duty_q  <= nduty;
				phase_q <= nph;
				en_q    <= en_next;
				if (clr_elapsed) begin
					elapsed_q <= '0;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_cmp_q   <= ncmp[10:0];
			out_on_q    <= en_next;
			out_phase_q <= nph;
			out_save_q  <= save_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_compare = out_cmp_q;
	assign motor_on      = out_on_q;
	assign phase         = out_phase_q;
	assign save_request  = out_save_q;
	assign blower_off    = out_save_q;

endmodule

// ----- hw/rtl/motor_soft_start_ramp.sv -----
// Soft start and soft stop ramp for a PWM motor. Each request is one 1 ms tick
// and yields one result. A tick occupies the block from acceptance until it
// commits, so a new request is accepted only after that; the steps in order are
// the accepting cycle, the rate multiply, the rate-times-elapsed multiply, the
// reciprocal multiply that estimates the duty step divided by 1000, a correction
// of that estimate by a compare and subtract, and the commit. The result sits
// in an output register, so the next request is taken while it waits; commit
// holds only while that register is still full. Configuration writes are taken
// at any time and should be made between ticks.
module motor_soft_start_ramp #(
	parameter int PERIOD = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_req,
	input  logic        stop_req,
	input  logic        min_temp_ok,
	input  logic [10:0] target_duty,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] motor_compare,
	output logic        motor_on,
	output logic [2:0]  phase,
	output logic        save_request,
	output logic        blower_off
);
	import msr_pkg::*;

	logic [10:0] min_start_duty_q;
	logic [15:0] accel_distance_q;
	ctrl_cmd_t   cmd;
	dp_sts_t     sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_start_duty_q <= 11'd153;
			accel_distance_q <= 16'd256;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MIN_DUTY:   min_start_duty_q <= cfg_data[10:0];
				CFG_ACCEL_DIST: accel_distance_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	msr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msr_datapath #(
		.PERIOD (PERIOD)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.min_start_duty (min_start_duty_q),
		.accel_distance (accel_distance_q),
		.start_req      (start_req),
		.stop_req       (stop_req),
		.min_temp_ok    (min_temp_ok),
		.target_duty    (target_duty),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.motor_compare  (motor_compare),
		.motor_on       (motor_on),
		.phase          (phase),
		.save_request   (save_request),
		.blower_off     (blower_off)
	);

endmodule

// ----- tb/tb_motor_soft_start_ramp.sv -----
module tb_motor_soft_start_ramp;
	import msr_pkg::*;

	localparam int PERIOD = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [10:0] cmp;
		logic        on;
		phase_t      ph;
		logic        save;
		logic        blower;
	} ramp_out_t;

	typedef struct packed {
		logic        start;
		logic        stop;
		logic        temp;
		logic [10:0] target;
		logic        typed;
		ramp_out_t   out;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        start_req;
	logic        stop_req;
	logic        min_temp_ok;
	logic [10:0] target_duty;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [10:0] motor_compare;
	logic        motor_on;
	logic [2:0]  phase;
	logic        save_request;
	logic        blower_off;

	logic [26:0] duty_q16;
	longint      ramp_rate;
	int          elapsed;
	phase_t      cur_phase;
	logic        motor_en;
	logic [10:0] min_duty;
	logic [15:0] accel_dist;

	ramp_out_t   pending_results[$];
	plan_row_t   opening_ticks[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          snd_pct;
	int          rcv_pct;
	int          ticks_sent;

	motor_soft_start_ramp #(
		.PERIOD(PERIOD)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.start_req    (start_req),
		.stop_req     (stop_req),
		.min_temp_ok  (min_temp_ok),
		.target_duty  (target_duty),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.motor_compare(motor_compare),
		.motor_on     (motor_on),
		.phase        (phase),
		.save_request (save_request),
		.blower_off   (blower_off)
	);

	always #5 clk = ~clk;

	function automatic longint rate_to(logic [26:0] end_q16);
		longint prod;
		prod = (longint'(end_q16) - longint'({min_duty, 16'd0})) * longint'(accel_dist);
		if (prod < 0)
			return -((-prod) >> 9);
		return prod >> 9;
	endfunction

	function automatic logic [10:0] compare_for(logic [26:0] d);
		logic [27:0] c;
		c = ({1'b0, d} + 28'h8000) >> 16;
		if (c > PERIOD)
			c = 28'(PERIOD);
		return c[10:0];
	endfunction

	function automatic void ramp_duty(logic up);
		longint inc;
		longint d;
		inc = (ramp_rate * elapsed) / 1000;
		d = up ? longint'(duty_q16) + inc : longint'(duty_q16) - inc;
		if (d < 0)
			d = 0;
		if (d > longint'(DUTY_MAX))
			d = longint'(DUTY_MAX);
		duty_q16 = d[26:0];
	endfunction

	function automatic ramp_out_t advance_ramp(logic start, logic stop, logic temp,
		logic [10:0] target);
		logic [26:0] min_q16;
		logic [26:0] tgt_q16;
		logic        drove;
		ramp_out_t   r;
		min_q16 = {min_duty, 16'd0};
		tgt_q16 = {target, 16'd0};
		drove = 1'b0;
		r = '0;
		if (elapsed < 65535)
			elapsed++;
		if (start) begin
			ramp_rate = rate_to(tgt_q16);
			cur_phase = PH_WAIT;
		end
		if (stop) begin
			ramp_rate = rate_to(duty_q16);
			cur_phase = PH_DECEL;
			elapsed = 0;
		end
		case (cur_phase)
			PH_WAIT: begin
				if (temp) begin
					cur_phase = PH_ACCEL;
					duty_q16 = min_q16;
					drove = 1'b1;
					elapsed = 0;
				end
			end
			PH_ACCEL: begin
				if (duty_q16 < tgt_q16) begin
					ramp_duty(1'b1);
				end else begin
					duty_q16 = tgt_q16;
					cur_phase = PH_WORK;
				end
				drove = 1'b1;
			end
			PH_WORK: begin
				duty_q16 = tgt_q16;
				drove = 1'b1;
			end
			PH_DECEL: begin
				if (duty_q16 > min_q16) begin
					ramp_duty(1'b0);
					drove = 1'b1;
				end else begin
					cur_phase = PH_STOP;
					duty_q16 = '0;
					motor_en = 1'b0;
					r.save = 1'b1;
					r.blower = 1'b1;
				end
			end
			default: cur_phase = PH_STOP;
		endcase
		if (drove && compare_for(duty_q16) > 1)
			motor_en = 1'b1;
		r.cmp = compare_for(duty_q16);
		r.on = motor_en;
		r.ph = cur_phase;
		return r;
	endfunction

	function automatic ramp_out_t outcome(logic [10:0] cmp, logic on, phase_t ph,
		logic save, logic blower);
		ramp_out_t r;
		r.cmp = cmp;
		r.on = on;
		r.ph = ph;
		r.save = save;
		r.blower = blower;
		return r;
	endfunction

	function automatic plan_row_t plan_row(logic start, logic stop, logic temp,
		logic [10:0] target, logic typed, ramp_out_t out);
		plan_row_t p;
		p.start = start;
		p.stop = stop;
		p.temp = temp;
		p.target = target;
		p.typed = typed;
		p.out = out;
		return p;
	endfunction

	task automatic send_tick(logic start, logic stop, logic temp, logic [10:0] target,
		logic typed, ramp_out_t typed_out);
		ramp_out_t predicted;
		while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= start;
		stop_req <= stop;
		min_temp_ok <= temp;
		target_duty <= target;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = advance_ramp(start, stop, temp, target);
		pending_results.push_back(typed ? typed_out : predicted);
		ticks_sent++;
	endtask

	task automatic session_tick(logic start, logic stop, logic temp, logic [10:0] target);
		if ($urandom_range(99) < 8) begin
			start = 1'($urandom_range(1));
			stop = 1'($urandom_range(1));
			temp = 1'($urandom_range(1));
			target = 11'($urandom_range(1024));
		end
		send_tick(start, stop, temp, target, 1'b0, '0);
	endtask

	task automatic run_session();
		logic [10:0] tgt;
		int          n;
		int          runs;
		tgt = $urandom_range(3) == 0 ? ($urandom_range(1) ? 11'd1024 : 11'd0) :
			11'($urandom_range(1024));
		session_tick(1'b1, 1'b0, 1'($urandom_range(1)), tgt);
		n = $urandom_range(3);
		repeat (n)
			session_tick(1'b0, 1'b0, 1'b0, tgt);
		runs = $urandom_range(1, 90);
		for (n = 0; n < runs; n++) begin
			if ($urandom_range(9) == 0)
				tgt = 11'($urandom_range(1024));
			session_tick($urandom_range(99) < 3, 1'b0, 1'b1, tgt);
		end
		session_tick(1'b0, 1'b1, 1'($urandom_range(1)), tgt);
		n = 0;
		while (cur_phase == PH_DECEL && n < 100) begin
			session_tick(1'b0, 1'b0, 1'($urandom_range(1)), 11'($urandom_range(1024)));
			n++;
		end
	endtask

	task automatic write_cfg(logic idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_MIN_DUTY)
			min_duty = val[10:0];
		else
			accel_dist = val;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [10:0] want, logic [10:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		ramp_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unrequested result: expected none, got compare %0d phase %0d",
					$time, motor_compare, phase);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("motor_compare", want.cmp, motor_compare);
				check_field("motor_on", 11'(want.on), 11'(motor_on));
				check_field("phase", 11'(want.ph), 11'(phase));
				check_field("save_request", 11'(want.save), 11'(save_request));
				check_field("blower_off", 11'(want.blower), 11'(blower_off));
			end
		end
		out_ready <= (rcv_pct == 0) || ($urandom_range(99) >= rcv_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("motor_soft_start_ramp regression: fail");
			$finish;
		end
	end

	initial begin
		int          i;
		int          mode;
		int          phase_end;
		logic [10:0] min_pick;
		logic [15:0] dist_pick;
		plan_row_t   row;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_MIN_DUTY;
		cfg_data = '0;
		in_valid = 1'b0;
		start_req = 1'b0;
		stop_req = 1'b0;
		min_temp_ok = 1'b0;
		target_duty = '0;
		snd_pct = 0;
		rcv_pct = 0;
		ticks_sent = 0;
		min_duty = 11'd153;
		accel_dist = 16'd256;
		duty_q16 = '0;
		ramp_rate = 0;
		elapsed = 0;
		cur_phase = PH_STOP;
		motor_en = 1'b0;

		opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b0, 11'd0, 1'b1,
			outcome(11'd0, 1'b0, PH_STOP, 1'b0, 1'b0)));
		opening_ticks.push_back(plan_row(1'b0, 1'b1, 1'b0, 11'd0, 1'b1,
			outcome(11'd0, 1'b0, PH_STOP, 1'b1, 1'b1)));
		opening_ticks.push_back(plan_row(1'b1, 1'b0, 1'b0, 11'd1024, 1'b1,
			outcome(11'd0, 1'b0, PH_WAIT, 1'b0, 1'b0)));
		opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b1, 11'd1024, 1'b1,
			outcome(11'd153, 1'b1, PH_ACCEL, 1'b0, 1'b0)));
		repeat (5)
			opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b1, 11'd1024, 1'b0, '0));
		opening_ticks.push_back(plan_row(1'b1, 1'b0, 1'b0, 11'd1024, 1'b0, '0));
		opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b1, 11'd1024, 1'b1,
			outcome(11'd153, 1'b1, PH_ACCEL, 1'b0, 1'b0)));
		repeat (3)
			opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b1, 11'd1024, 1'b0, '0));
		opening_ticks.push_back(plan_row(1'b0, 1'b1, 1'b1, 11'd1024, 1'b0, '0));
		repeat (3)
			opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b0, 11'd0, 1'b0, '0));
		opening_ticks.push_back(plan_row(1'b1, 1'b1, 1'b1, 11'd512, 1'b0, '0));
		opening_ticks.push_back(plan_row(1'b1, 1'b0, 1'b1, 11'd0, 1'b1,
			outcome(11'd153, 1'b1, PH_ACCEL, 1'b0, 1'b0)));
		opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b1, 11'd0, 1'b1,
			outcome(11'd0, 1'b1, PH_WORK, 1'b0, 1'b0)));
		opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b0, 11'd1024, 1'b1,
			outcome(11'd1024, 1'b1, PH_WORK, 1'b0, 1'b0)));
		opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b0, 11'd1, 1'b1,
			outcome(11'd1, 1'b1, PH_WORK, 1'b0, 1'b0)));
		opening_ticks.push_back(plan_row(1'b0, 1'b1, 1'b0, 11'd1, 1'b1,
			outcome(11'd0, 1'b0, PH_STOP, 1'b1, 1'b1)));
		opening_ticks.push_back(plan_row(1'b0, 1'b0, 1'b1, 11'd1024, 1'b1,
			outcome(11'd0, 1'b0, PH_STOP, 1'b0, 1'b0)));

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_ticks[k]) begin
			row = opening_ticks[k];
			send_tick(row.start, row.stop, row.temp, row.target, row.typed, row.out);
		end
		drain();

		for (i = 0; i < 8; i++) begin
			case (i)
				0: begin min_pick = 11'd0;    dist_pick = 16'hFFFF; end
				1: begin min_pick = 11'd1024; dist_pick = 16'd0;    end
				2: begin min_pick = 11'd153;  dist_pick = 16'd256;  end
				3: begin min_pick = 11'd0;    dist_pick = 16'd1;    end
				4: begin min_pick = 11'd1024; dist_pick = 16'hFFFF; end
				5: begin
					min_pick = 11'($urandom_range(1024));
					dist_pick = 16'($urandom_range(1, 2048));
				end
				6: begin
					min_pick = 11'($urandom_range(1024));
					dist_pick = 16'($urandom_range(65535));
				end
				default: begin
					min_pick = 11'($urandom_range(1024));
					dist_pick = 16'($urandom_range(64, 1024));
				end
			endcase
			write_cfg(CFG_MIN_DUTY, {5'd0, min_pick});
			write_cfg(CFG_ACCEL_DIST, dist_pick);
			cfg_wr_en <= 1'b0;
			mode = i % 4;
			snd_pct = (mode == 1) ? 88 : (mode == 3) ? 13 : 0;
			rcv_pct = (mode == 2) ? 88 : (mode == 3) ? 13 : 0;
			phase_end = ticks_sent + 100;
			while (ticks_sent < phase_end)
				run_session();
			drain();
			snd_pct = 0;
			rcv_pct = 0;
		end

		if (mismatches == 0)
			$display("motor_soft_start_ramp regression: pass");
		else
			$display("motor_soft_start_ramp regression: fail");
		$finish;
	end

endmodule
